>>> sv/semaphore_wait_queue_table_macros.svh
// Assertion macros shared by the semaphore wait-queue table modules.
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SWQT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swqt assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SWQT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swqt assertion failed");
`else
`define SWQT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SWQT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/swqt_pkg.sv
// Package with the types, codes and constants of the semaphore wait-queue table.
package swqt_pkg;

    // Field widths of the request and response transfers.
    localparam int ACTION_W  = 3;
    localparam int SEM_KEY_W = 32;
    localparam int PROC_ID_W = 5;

    // Default sizing.
    localparam int NUM_PROCS_DEF = 32;
    localparam int KEY_BITS_DEF  = 32;

    // Action codes of a request.
    typedef enum logic [ACTION_W-1:0] {
        ACT_BLOCK   = 3'd0,
        ACT_UNBLOCK = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_QUERY   = 3'd3,
        ACT_PEEK    = 3'd4
    } t_action;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_INIT,
        S_SCAN,
        S_FULL,
        S_H_RD,
        S_H_USE,
        S_U_RD1,
        S_U_RD2,
        S_U_CHK,
        S_U_WALK,
        S_U_END,
        S_B_TAIL,
        S_B_LINK,
        S_B_NEW,
        S_B_FIN,
        S_DONE
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_QUERY,
        OP_SET_REMOVE,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_SET_FULL,
        OP_HEAD_RD,
        OP_HEAD_USE,
        OP_U_RD1,
        OP_U_RD2,
        OP_U_CHK,
        OP_U_WALK,
        OP_U_END,
        OP_B_TAIL,
        OP_B_LINK,
        OP_B_NEW,
        OP_B_FIN,
        OP_OUT
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic                in_valid;
        logic [ACTION_W-1:0] action;
        logic                key_zero;
        logic                pid_ok;
        logic                waiting_p;
        logic                scan_done;
        logic                match;
        logic                free_ok;
        logic                head_is_p;
        logic                nx_is_p;
        logic                cur_is_tail;
        logic                walk_limit;
        logic                out_free;
    } t_dp_sts;

endpackage

>>> sv/swqt_if.sv
// Request and response channel interfaces of the semaphore wait-queue table.
interface swqt_in_if;
    logic                            valid;
    logic                            ready;
    logic [swqt_pkg::ACTION_W-1:0]   action;
    logic [swqt_pkg::SEM_KEY_W-1:0]  sem_key;
    logic [swqt_pkg::PROC_ID_W-1:0]  proc_id;

    modport source (output valid, output action, output sem_key, output proc_id, input ready);
    modport sink   (input valid, input action, input sem_key, input proc_id, output ready);
endinterface

interface swqt_out_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic                            found;
    logic [swqt_pkg::PROC_ID_W-1:0]  proc_out;

    modport source (output valid, output status, output found, output proc_out, input ready);
    modport sink   (input valid, input status, input found, input proc_out, output ready);
endinterface

>>> sv/swqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/swqt_datapath.sv
// Datapath of the semaphore wait-queue table: descriptor and queue stores, scan and walk.
`include "semaphore_wait_queue_table_macros.svh"
module swqt_datapath #(
    parameter int NUM_PROCS = swqt_pkg::NUM_PROCS_DEF,
    parameter int KEY_BITS  = swqt_pkg::KEY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    swqt_in_if.sink            i_in,
    swqt_out_if.source         o_out,
    input  swqt_pkg::t_dp_cmd  i_cmd,
    output swqt_pkg::t_dp_sts  o_sts
);
    localparam int PW   = $clog2(NUM_PROCS);
    localparam int CW   = $clog2(NUM_PROCS + 1);
    localparam int PIDW = swqt_pkg::PROC_ID_W;
    localparam logic [CW-1:0] CNT_END  = CW'(NUM_PROCS);
    localparam logic [PW-1:0] LAST_IDX = PW'(NUM_PROCS - 1);

    // Latched request.
    logic [swqt_pkg::ACTION_W-1:0] r_action;
    logic [KEY_BITS-1:0]           r_key;
    logic                          r_pid_ok;
    logic [PW-1:0]                 r_p;

    // Unlink and walk state.
    logic [PW-1:0] r_d;
    logic [PW-1:0] r_pnext;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] r_tail;
    logic [PW-1:0] r_walk;

    // Key scan state.
    logic [CW-1:0] r_cnt;
    logic          r_chk_v;
    logic [PW-1:0] r_chk_idx;
    logic          r_match_v;
    logic [PW-1:0] r_match_idx;
    logic          r_free_v;
    logic [PW-1:0] r_free_idx;

    // Result under construction and output register.
    logic          r_res_status;
    logic          r_res_found;
    logic [PW-1:0] r_res_pout;
    logic          r_out_valid;
    logic          r_out_status;
    logic          r_out_found;
    logic [PIDW-1:0] r_out_pout;

    // Per-entry flags.
    logic [NUM_PROCS-1:0] r_active;
    logic [NUM_PROCS-1:0] r_waiting;

    // RAM ports.
    logic                key_we;
    logic [PW-1:0]       key_waddr, key_raddr;
    logic [KEY_BITS-1:0] key_wdata, key_q;
    logic                head_we, tail_we, next_we, desc_we;
    logic [PW-1:0]       head_waddr, head_wdata, head_raddr, head_q;
    logic [PW-1:0]       tail_waddr, tail_wdata, tail_raddr, tail_q;
    logic [PW-1:0]       next_waddr, next_wdata, next_raddr, next_q;
    logic [PW-1:0]       desc_waddr, desc_wdata, desc_raddr, desc_q;

    swqt_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_PROCS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(key_wdata),
        .i_raddr(key_raddr), .o_rdata(key_q)
    );
    swqt_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_head_ram (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_q)
    );
    swqt_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_tail_ram (
        .i_clk(i_clk), .i_we(tail_we), .i_waddr(tail_waddr), .i_wdata(tail_wdata),
        .i_raddr(tail_raddr), .o_rdata(tail_q)
    );
    swqt_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(next_raddr), .o_rdata(next_q)
    );
    swqt_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_desc_ram (
        .i_clk(i_clk), .i_we(desc_we), .i_waddr(desc_waddr), .i_wdata(desc_wdata),
        .i_raddr(desc_raddr), .o_rdata(desc_q)
    );

    // RAM addressing and writes for each operation.
    always_comb begin
        key_we     = 1'b0;
        key_waddr  = r_free_idx;
        key_wdata  = r_key;
        key_raddr  = r_cnt[PW-1:0];
        head_we    = 1'b0;
        head_waddr = r_d;
        head_wdata = r_pnext;
        head_raddr = r_match_idx;
        tail_we    = 1'b0;
        tail_waddr = r_d;
        tail_wdata = r_p;
        tail_raddr = r_match_idx;
        next_we    = 1'b0;
        next_waddr = r_p;
        next_wdata = r_p;
        next_raddr = r_p;
        desc_we    = 1'b0;
        desc_waddr = r_p;
        desc_wdata = r_d;
        desc_raddr = r_p;
        unique case (i_cmd.op)
            swqt_pkg::OP_U_RD2: begin
                head_raddr = desc_q;
                tail_raddr = desc_q;
            end
            swqt_pkg::OP_U_CHK: begin
                next_raddr = head_q;
                if (head_q == r_p && tail_q != r_p) begin
                    head_we = 1'b1;
                end
            end
            swqt_pkg::OP_U_WALK: begin
                next_raddr = next_q;
                if (next_q == r_p) begin
                    next_we    = 1'b1;
                    next_waddr = r_cur;
                    next_wdata = r_pnext;
                    if (r_tail == r_p) begin
                        tail_we    = 1'b1;
                        tail_wdata = r_cur;
                    end
                end
            end
            swqt_pkg::OP_B_LINK: begin
                next_we    = 1'b1;
                next_waddr = tail_q;
                tail_we    = 1'b1;
            end
            swqt_pkg::OP_B_NEW: begin
                key_we     = 1'b1;
                head_we    = 1'b1;
                head_waddr = r_free_idx;
                head_wdata = r_p;
                tail_we    = 1'b1;
                tail_waddr = r_free_idx;
            end
            swqt_pkg::OP_B_FIN: begin
                next_we = 1'b1;
                desc_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control flags: descriptor pool, blocked processes, scan pipe, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_waiting   <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                swqt_pkg::OP_SCAN_INIT: r_chk_v <= 1'b0;
                swqt_pkg::OP_SCAN:      r_chk_v <= (r_cnt != CNT_END);
                swqt_pkg::OP_U_CHK: begin
                    if (head_q == r_p && tail_q == r_p) begin
                        r_active[r_d] <= 1'b0;
                    end
                end
                swqt_pkg::OP_U_END: r_waiting[r_p]      <= 1'b0;
                swqt_pkg::OP_B_NEW: r_active[r_free_idx] <= 1'b1;
                swqt_pkg::OP_B_FIN: r_waiting[r_p]      <= 1'b1;
                default: begin
                end
            endcase
            if (i_cmd.op == swqt_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            swqt_pkg::OP_LOAD: begin
                r_action     <= i_in.action;
                r_key        <= KEY_BITS'(i_in.sem_key);
                r_pid_ok     <= 32'(i_in.proc_id) < 32'(NUM_PROCS);
                r_p          <= PW'(i_in.proc_id);
                r_res_status <= 1'b0;
                r_res_found  <= 1'b0;
                r_res_pout   <= '0;
            end
            swqt_pkg::OP_SET_QUERY:  r_res_found <= r_pid_ok && r_waiting[r_p];
            swqt_pkg::OP_SET_REMOVE: begin
                r_res_found <= 1'b1;
                r_res_pout  <= r_p;
            end
            swqt_pkg::OP_SCAN_INIT: begin
                r_cnt     <= '0;
                r_match_v <= 1'b0;
                r_free_v  <= 1'b0;
            end
            swqt_pkg::OP_SCAN: begin
                if (r_cnt != CNT_END) begin
                    r_cnt     <= r_cnt + 1'b1;
                    r_chk_idx <= r_cnt[PW-1:0];
                end
                // Compare the entry read in the previous cycle.
                if (r_chk_v) begin
                    if (r_active[r_chk_idx] && key_q == r_key && !r_match_v) begin
                        r_match_v   <= 1'b1;
                        r_match_idx <= r_chk_idx;
                    end
                    if (!r_active[r_chk_idx] && !r_free_v) begin
                        r_free_v   <= 1'b1;
                        r_free_idx <= r_chk_idx;
                    end
                end
            end
            swqt_pkg::OP_SET_FULL: r_res_status <= 1'b1;
            swqt_pkg::OP_HEAD_USE: begin
                r_res_found <= 1'b1;
                r_res_pout  <= head_q;
                r_p         <= head_q;
            end
            swqt_pkg::OP_U_RD2: begin
                r_d     <= desc_q;
                r_pnext <= next_q;
            end
            swqt_pkg::OP_U_CHK: begin
                r_cur  <= head_q;
                r_tail <= tail_q;
                r_walk <= '0;
            end
            swqt_pkg::OP_U_WALK: begin
                r_cur  <= next_q;
                r_walk <= r_walk + 1'b1;
            end
            swqt_pkg::OP_B_TAIL: r_d <= r_match_idx;
            swqt_pkg::OP_B_NEW:  r_d <= r_free_idx;
            swqt_pkg::OP_OUT: begin
                r_out_status <= r_res_status;
                r_out_found  <= r_res_found;
                r_out_pout   <= PIDW'(r_res_pout);
            end
            default: begin
            end
        endcase
    end

    // Status to the controller.
    always_comb begin
        o_sts.in_valid    = i_in.valid;
        o_sts.action      = r_action;
        o_sts.key_zero    = (r_key == '0);
        o_sts.pid_ok      = r_pid_ok;
        o_sts.waiting_p   = r_waiting[r_p];
        o_sts.scan_done   = (r_cnt == CNT_END) && !r_chk_v;
        o_sts.match       = r_match_v;
        o_sts.free_ok     = r_free_v;
        o_sts.head_is_p   = (head_q == r_p);
        o_sts.nx_is_p     = (next_q == r_p);
        o_sts.cur_is_tail = (r_cur == r_tail);
        o_sts.walk_limit  = (r_walk == LAST_IDX);
        o_sts.out_free    = !r_out_valid || o_out.ready;
    end

    assign i_in.ready     = i_cmd.in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out_status;
    assign o_out.found    = r_out_found;
    assign o_out.proc_out = r_out_pout;

    `SWQT_ASSERT_NEXT(a_fin_sets_wait, i_clk, i_rst_n, i_cmd.op == swqt_pkg::OP_B_FIN, r_waiting[$past(r_p)])
    `SWQT_ASSERT_NEXT(a_new_takes_desc, i_clk, i_rst_n, i_cmd.op == swqt_pkg::OP_B_NEW, r_active[$past(r_free_idx)])
    `SWQT_ASSERT_IMPL(a_out_slot_free, i_clk, i_rst_n, i_cmd.op == swqt_pkg::OP_OUT, !r_out_valid || o_out.ready)
endmodule

>>> sv/swqt_ctrl.sv
// Controller state machine of the semaphore wait-queue table.
`include "semaphore_wait_queue_table_macros.svh"
module swqt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swqt_pkg::t_dp_sts  i_sts,
    output swqt_pkg::t_dp_cmd  o_cmd
);
    swqt_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swqt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = swqt_pkg::OP_NONE;
        unique case (r_state)
            swqt_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.op = swqt_pkg::OP_LOAD;
                    n_state  = swqt_pkg::S_DECODE;
                end
            end
            swqt_pkg::S_DECODE: begin
                n_state = swqt_pkg::S_DONE;
                unique case (i_sts.action)
                    swqt_pkg::ACT_BLOCK: begin
                        if (!i_sts.key_zero && i_sts.pid_ok) begin
                            n_state = i_sts.waiting_p ? swqt_pkg::S_U_RD1
                                                      : swqt_pkg::S_SCAN_INIT;
                        end
                    end
                    swqt_pkg::ACT_UNBLOCK, swqt_pkg::ACT_PEEK: begin
                        if (!i_sts.key_zero) begin
                            n_state = swqt_pkg::S_SCAN_INIT;
                        end
                    end
                    swqt_pkg::ACT_REMOVE: begin
                        if (i_sts.pid_ok && i_sts.waiting_p) begin
                            o_cmd.op = swqt_pkg::OP_SET_REMOVE;
                            n_state  = swqt_pkg::S_U_RD1;
                        end
                    end
                    swqt_pkg::ACT_QUERY: o_cmd.op = swqt_pkg::OP_SET_QUERY;
                    default: begin
                    end
                endcase
            end
            swqt_pkg::S_SCAN_INIT: begin
                o_cmd.op = swqt_pkg::OP_SCAN_INIT;
                n_state  = swqt_pkg::S_SCAN;
            end
            swqt_pkg::S_SCAN: begin
                o_cmd.op = swqt_pkg::OP_SCAN;
                if (i_sts.scan_done) begin
                    if (i_sts.action == swqt_pkg::ACT_BLOCK) begin
                        priority if (i_sts.match) n_state = swqt_pkg::S_B_TAIL;
                        else if (i_sts.free_ok)   n_state = swqt_pkg::S_B_NEW;
                        else                      n_state = swqt_pkg::S_FULL;
                    end else begin
                        n_state = i_sts.match ? swqt_pkg::S_H_RD : swqt_pkg::S_DONE;
                    end
                end
            end
            swqt_pkg::S_FULL: begin
                o_cmd.op = swqt_pkg::OP_SET_FULL;
                n_state  = swqt_pkg::S_DONE;
            end
            swqt_pkg::S_H_RD: begin
                o_cmd.op = swqt_pkg::OP_HEAD_RD;
                n_state  = swqt_pkg::S_H_USE;
            end
            swqt_pkg::S_H_USE: begin
                o_cmd.op = swqt_pkg::OP_HEAD_USE;
                n_state  = (i_sts.action == swqt_pkg::ACT_UNBLOCK) ? swqt_pkg::S_U_RD1
                                                                   : swqt_pkg::S_DONE;
            end
            swqt_pkg::S_U_RD1: begin
                o_cmd.op = swqt_pkg::OP_U_RD1;
                n_state  = swqt_pkg::S_U_RD2;
            end
            swqt_pkg::S_U_RD2: begin
                o_cmd.op = swqt_pkg::OP_U_RD2;
                n_state  = swqt_pkg::S_U_CHK;
            end
            swqt_pkg::S_U_CHK: begin
                o_cmd.op = swqt_pkg::OP_U_CHK;
                n_state  = i_sts.head_is_p ? swqt_pkg::S_U_END : swqt_pkg::S_U_WALK;
            end
            swqt_pkg::S_U_WALK: begin
                o_cmd.op = swqt_pkg::OP_U_WALK;
                if (i_sts.nx_is_p || i_sts.cur_is_tail || i_sts.walk_limit) begin
                    n_state = swqt_pkg::S_U_END;
                end
            end
            swqt_pkg::S_U_END: begin
                o_cmd.op = swqt_pkg::OP_U_END;
                n_state  = (i_sts.action == swqt_pkg::ACT_BLOCK) ? swqt_pkg::S_SCAN_INIT
                                                                 : swqt_pkg::S_DONE;
            end
            swqt_pkg::S_B_TAIL: begin
                o_cmd.op = swqt_pkg::OP_B_TAIL;
                n_state  = swqt_pkg::S_B_LINK;
            end
            swqt_pkg::S_B_LINK: begin
                o_cmd.op = swqt_pkg::OP_B_LINK;
                n_state  = swqt_pkg::S_B_FIN;
            end
            swqt_pkg::S_B_NEW: begin
                o_cmd.op = swqt_pkg::OP_B_NEW;
                n_state  = swqt_pkg::S_B_FIN;
            end
            swqt_pkg::S_B_FIN: begin
                o_cmd.op = swqt_pkg::OP_B_FIN;
                n_state  = swqt_pkg::S_DONE;
            end
            swqt_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = swqt_pkg::OP_OUT;
                    n_state  = swqt_pkg::S_IDLE;
                end
            end
            default: n_state = swqt_pkg::S_IDLE;
        endcase
    end

    `SWQT_ASSERT_NEXT(a_accept_to_decode, i_clk, i_rst_n, r_state == swqt_pkg::S_IDLE && i_sts.in_valid, r_state == swqt_pkg::S_DECODE)
    `SWQT_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, r_state == swqt_pkg::S_DONE && i_sts.out_free, r_state == swqt_pkg::S_IDLE)
    `SWQT_ASSERT_IMPL(a_scan_ends_known, i_clk, i_rst_n, r_state == swqt_pkg::S_FULL, !i_sts.match && !i_sts.free_ok)
endmodule

>>> sv/semaphore_wait_queue_table.sv
// Top level of the semaphore wait-queue table.
// One request is handled at a time and gives exactly one response. Query and
// invalid requests go from decode straight to the response; unblock, peek and
// block of a process that is not waiting run a key scan that reads the key RAM
// one descriptor per cycle. Unblock, remove and a block of an already waiting
// process add an unlink that walks the singly linked queue one entry per cycle
// through the next-pointer RAM. A finished response sits in an output register
// while the next request is taken; no clearing pass is needed after reset.
module semaphore_wait_queue_table #(
    parameter int NUM_PROCS = swqt_pkg::NUM_PROCS_DEF,
    parameter int KEY_BITS  = swqt_pkg::KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swqt_in_if.sink    i_in,
    swqt_out_if.source o_out
);
    swqt_pkg::t_dp_cmd cmd;
    swqt_pkg::t_dp_sts sts;

    swqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    swqt_datapath #(
        .NUM_PROCS (NUM_PROCS),
        .KEY_BITS  (KEY_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule

>>> test/tb_semaphore_wait_queue_table.sv
// Testbench for the semaphore wait-queue table: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module tb_semaphore_wait_queue_table;

    localparam int NP = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    swqt_in_if  req_ch ();
    swqt_out_if rsp_ch ();

    semaphore_wait_queue_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // One expected response.
    typedef struct {
        logic       status;
        logic       found;
        logic [4:0] proc_out;
    } t_rsp;

    // Predictor state of the table.
    logic [31:0] sem_key_of  [NP];
    logic        sem_in_use  [NP];
    logic [4:0]  q_head      [NP];
    logic [4:0]  q_tail      [NP];
    logic [4:0]  next_proc   [NP];
    logic        is_blocked  [NP];
    logic [4:0]  desc_of_proc[NP];

    t_rsp pending_rsp[$];
    int   n_errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_off = 1'b0;

    // Returns the active descriptor with this key, or -1.
    function automatic int lookup_sem(logic [31:0] key);
        for (int d = 0; d < NP; d++)
            if (sem_in_use[d] && sem_key_of[d] == key) return d;
        return -1;
    endfunction

    // Takes a blocked process out of its queue; frees an emptied descriptor.
    function automatic void detach_proc(logic [4:0] p);
        logic [4:0] d;
        logic [4:0] cur;
        logic [4:0] nx;
        d = desc_of_proc[p];
        cur = q_head[d];
        if (cur == p) begin
            if (q_tail[d] == p) begin
                sem_in_use[d] = 1'b0;
                sem_key_of[d] = '0;
            end else begin
                q_head[d] = next_proc[p];
            end
        end else begin
            for (int s = 0; s < NP; s++) begin
                nx = next_proc[cur];
                if (nx == p) begin
                    next_proc[cur] = next_proc[p];
                    if (q_tail[d] == p) q_tail[d] = cur;
                    break;
                end
                if (cur == q_tail[d]) break;
                cur = nx;
            end
        end
        is_blocked[p] = 1'b0;
    endfunction

    // Applies one request to the predictor and returns the response.
    function automatic t_rsp apply_request(logic [2:0] act, logic [31:0] key, logic [4:0] p);
        t_rsp r;
        int   d;
        r = '{1'b0, 1'b0, 5'd0};
        case (act)
            swqt_pkg::ACT_BLOCK: begin
                if (key != 0) begin
                    if (is_blocked[p]) detach_proc(p);
                    d = lookup_sem(key);
                    if (d < 0) begin
                        for (int k = 0; k < NP; k++)
                            if (!sem_in_use[k]) begin
                                d = k;
                                break;
                            end
                        if (d < 0) begin
                            r.status = 1'b1;
                            return r;
                        end
                        sem_in_use[d] = 1'b1;
                        sem_key_of[d] = key;
                        q_head[d] = p;
                    end else begin
                        next_proc[q_tail[d]] = p;
                    end
                    q_tail[d] = p;
                    next_proc[p] = p;
                    desc_of_proc[p] = 5'(d);
                    is_blocked[p] = 1'b1;
                end
            end
            swqt_pkg::ACT_UNBLOCK: begin
                if (key != 0) begin
                    d = lookup_sem(key);
                    if (d >= 0) begin
                        r.found = 1'b1;
                        r.proc_out = q_head[d];
                        detach_proc(q_head[d]);
                    end
                end
            end
            swqt_pkg::ACT_REMOVE: begin
                if (is_blocked[p]) begin
                    detach_proc(p);
                    r.found = 1'b1;
                    r.proc_out = p;
                end
            end
            swqt_pkg::ACT_QUERY: r.found = is_blocked[p];
            swqt_pkg::ACT_PEEK: begin
                if (key != 0) begin
                    d = lookup_sem(key);
                    if (d >= 0) begin
                        r.found = 1'b1;
                        r.proc_out = q_head[d];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sends one request and records the expected response at its transfer.
    // Valid stays high after a transfer; idling or draining drops it.
    task automatic send_request(logic [2:0] act, logic [31:0] key, logic [4:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.sem_key <= key;
        req_ch.proc_id <= p;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(apply_request(act, key, p));
    endtask

    // Response side: random stalls and the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checks each response transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected response status=%0b found=%0b proc_out=%0d",
                       rsp_ch.status, rsp_ch.found, rsp_ch.proc_out);
                n_errors++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_ch.status !== exp_rsp.status) begin
                    $error("status expected %0b actual %0b", exp_rsp.status, rsp_ch.status);
                    n_errors++;
                end
                if (rsp_ch.found !== exp_rsp.found) begin
                    $error("found expected %0b actual %0b", exp_rsp.found, rsp_ch.found);
                    n_errors++;
                end
                if (rsp_ch.proc_out !== exp_rsp.proc_out) begin
                    $error("proc_out expected %0d actual %0d", exp_rsp.proc_out,
                           rsp_ch.proc_out);
                    n_errors++;
                end
            end
        end
    end

    // Stops offering requests and waits until every expected response has arrived.
    task automatic drain_responses();
        if (req_ch.valid) req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Random key, mostly from a small set so that queues build up.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'hFFFF_FFF0 + $urandom_range(15);
            2: return 32'd0;
            default: return 32'(1 + $urandom_range(6));
        endcase
    endfunction

    task automatic test_directed();
        send_request(swqt_pkg::ACT_QUERY, 32'd0, 5'd0);
        send_request(swqt_pkg::ACT_UNBLOCK, 32'd5, 5'd0);
        send_request(swqt_pkg::ACT_PEEK, 32'd5, 5'd0);
        send_request(swqt_pkg::ACT_REMOVE, 32'd0, 5'd31);
        send_request(swqt_pkg::ACT_BLOCK, 32'd0, 5'd3);
        send_request(swqt_pkg::ACT_BLOCK, 32'hFFFF_FFFF, 5'd31);
        send_request(swqt_pkg::ACT_BLOCK, 32'hFFFF_FFFF, 5'd0);
        send_request(swqt_pkg::ACT_BLOCK, 32'hFFFF_FFFF, 5'd7);
        send_request(swqt_pkg::ACT_PEEK, 32'hFFFF_FFFF, 5'd0);
        send_request(swqt_pkg::ACT_QUERY, 32'd0, 5'd31);
        send_request(swqt_pkg::ACT_REMOVE, 32'd0, 5'd0);
        send_request(swqt_pkg::ACT_BLOCK, 32'h1234_5678, 5'd7);
        send_request(swqt_pkg::ACT_UNBLOCK, 32'hFFFF_FFFF, 5'd0);
        send_request(swqt_pkg::ACT_UNBLOCK, 32'hFFFF_FFFF, 5'd0);
        send_request(swqt_pkg::ACT_UNBLOCK, 32'd0, 5'd0);
        send_request(swqt_pkg::ACT_PEEK, 32'd0, 5'd0);
        send_request(3'd5, 32'h1234_5678, 5'd7);
        send_request(3'd6, 32'hAAAA_5555, 5'd21);
        send_request(3'd7, 32'h5555_AAAA, 5'd10);
        send_request(swqt_pkg::ACT_REMOVE, 32'd0, 5'd7);
        drain_responses();
    endtask

    // Each process blocks on its own key, filling the pool; then a fresh key
    // reuses the descriptor freed by the process's own unlink.
    task automatic test_pool_exhaustion();
        for (int p = 0; p < NP; p++) send_request(swqt_pkg::ACT_BLOCK, 32'(100 + p), 5'(p));
        send_request(swqt_pkg::ACT_BLOCK, 32'd999, 5'd5);
        send_request(swqt_pkg::ACT_QUERY, 32'd0, 5'd5);
        send_request(swqt_pkg::ACT_BLOCK, 32'd101, 5'd4);
        for (int p = 0; p < NP; p++) send_request(swqt_pkg::ACT_REMOVE, 32'd0, 5'(p));
        drain_responses();
    endtask

    // Random requests weighted toward building and draining queues.
    task automatic test_random(int n);
        logic [2:0] act;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: act = swqt_pkg::ACT_BLOCK;
                7, 8, 9:             act = swqt_pkg::ACT_UNBLOCK;
                10, 11, 12:          act = swqt_pkg::ACT_REMOVE;
                13, 14:              act = swqt_pkg::ACT_QUERY;
                15, 16, 17:          act = swqt_pkg::ACT_PEEK;
                default:             act = 3'($urandom_range(7));
            endcase
            send_request(act, pick_key(), 5'($urandom_range(31)));
        end
    endtask

    // Response side held off while requests keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(20);
        join
        drain_responses();
    endtask

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.action  = '0;
        req_ch.sem_key = '0;
        req_ch.proc_id = '0;
        for (int k = 0; k < NP; k++) begin
            sem_key_of[k] = '0;
            sem_in_use[k] = 1'b0;
            is_blocked[k] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pool_exhaustion();
        test_random(150);
        send_idle_pct = 50;
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 50;
        test_random(150);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain_responses();
        repeat (100) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("[semaphore_wait_queue_table] OK");
        end else begin
            $display("[semaphore_wait_queue_table] ERROR");
        end
        $finish;
    end

    // Run limit far above the slowest correct run.
    initial begin
        #20ms;
        $display("[semaphore_wait_queue_table] ERROR");
        $finish;
    end

endmodule
